### rtl/lpf_pkg.sv
// Shared types, constants and compare functions of the longest previous factor unit.
`default_nettype none

package lpf_pkg;

    // Field widths of the suffix array stream.
    localparam int POS_BITS = 16;
    localparam int LEN_BITS = 16;

    // Default stack depth and depth of the queue between front and back.
    localparam int STACK_DEPTH_DEF = 64;
    localparam int QUEUE_DEPTH     = 2;

    typedef logic [POS_BITS-1:0] pos_t;
    typedef logic [LEN_BITS-1:0] len_t;

    // One rank of the suffix array and LCP array.
    typedef struct packed {
        pos_t suffix_pos;
        len_t lcp_len;
        logic flush;
    } lpf_in_t;

    // One longest previous factor result.
    typedef struct packed {
        pos_t factor_pos;
        len_t factor_len;
        logic last_of_run;
        logic overflow;
    } lpf_out_t;

    // Classified item handed from the front to the back.
    typedef struct packed {
        pos_t pos;
        len_t cur;
        logic flush;
    } lpf_cmd_t;

    // True when the incoming item is a flush or sorts below the stack top, and takes the max/min path.
    function automatic logic below_top(input logic flush, input pos_t pos, input pos_t top_pos);
        below_top = flush || (pos < top_pos);
    endfunction

    // True when the stack top is popped by the incoming item.
    function automatic logic pop_cond(input logic flush, input pos_t pos, input len_t cur,
                                      input pos_t top_pos, input len_t top_len);
        pop_cond = below_top(flush, pos, top_pos) || ((pos > top_pos) && (cur <= top_len));
    endfunction

endpackage

`default_nettype wire

### rtl/longest_previous_factor_unit.sv
// Top level of the longest previous factor unit: front queue, stack engine and checks.
//
// The unit takes a suffix array and its LCP array one rank per transfer and returns, for
// every stack entry that is popped, the text position and its longest previous factor
// length, in pop order, with last_of_run marking the final result of an input item and
// overflow giving the sticky flag for a push that found the stack full. An item whose
// processing pops k entries occupies the stack engine for its k pops and then its push:
// the engine pops one entry per cycle while the output is not stalled, and it takes the
// next queued item in that push cycle. Every entry is pushed once and popped at most once.
// A two-entry queue sits between the input and the engine, and results leave through an
// output register, so both sides may stall independently. The stack needs no clearing
// after reset; the unit takes transfers as soon as reset is released.
`default_nettype none

module longest_previous_factor_unit #(
    parameter int STACK_DEPTH = lpf_pkg::STACK_DEPTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               sa_valid,
    output logic                    sa_stall,
    input  wire lpf_pkg::lpf_in_t   sa_item,
    output logic                    lpf_valid,
    input  wire logic               lpf_stall,
    output lpf_pkg::lpf_out_t       lpf_item
);
    import lpf_pkg::*;

    logic      cmd_valid;
    logic      cmd_take;
    lpf_cmd_t  cmd;

    lpf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .sa_valid  (sa_valid),
        .sa_stall  (sa_stall),
        .sa_item   (sa_item),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd)
    );

    lpf_engine #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd),
        .lpf_valid (lpf_valid),
        .lpf_stall (lpf_stall),
        .lpf_item  (lpf_item)
    );

    // The engine only takes an item that the queue holds.
    assert property (@(posedge clk) disable iff (!rst_n) cmd_take |-> cmd_valid)
        else $error("engine took an item from an empty queue");

    // A full queue always offers an item to the engine.
    assert property (@(posedge clk) disable iff (!rst_n) sa_stall |-> cmd_valid)
        else $error("input stalled while the queue offers nothing");

    // Once a result reports overflow, every later result reports it too.
    assert property (@(posedge clk) disable iff (!rst_n)
        (lpf_valid && lpf_item.overflow) |=> (!lpf_valid || lpf_item.overflow))
        else $error("overflow flag cleared without reset");

endmodule

`default_nettype wire

### rtl/lpf_front.sv
// Front part: takes input transfers, classifies them and queues them for the back part.
`default_nettype none

module lpf_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              sa_valid,
    output logic                   sa_stall,
    input  wire lpf_pkg::lpf_in_t  sa_item,
    output logic                   cmd_valid,
    input  wire logic              cmd_take,
    output lpf_pkg::lpf_cmd_t      cmd
);
    import lpf_pkg::*;

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [QCW-1:0] FULL_C = QCW'(QUEUE_DEPTH);
    localparam logic [QAW-1:0] LAST_C = QAW'(QUEUE_DEPTH - 1);

    lpf_cmd_t         queue_reg [QUEUE_DEPTH];
    logic [QAW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]   fill_reg, fill_next;
    logic             accept;
    lpf_cmd_t         classified;

    // A flush item enters the stack logic as a position below all others with lcp zero.
    always_comb
    begin
        classified.pos   = sa_item.suffix_pos;
        classified.cur   = sa_item.flush ? '0 : sa_item.lcp_len;
        classified.flush = sa_item.flush;
    end

    assign sa_stall  = (fill_reg == FULL_C);
    assign accept    = sa_valid && !sa_stall;
    assign cmd_valid = (fill_reg != '0);
    assign cmd       = queue_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (accept)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_C) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (cmd_take)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_C) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (accept && !cmd_take)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (!accept && cmd_take)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            queue_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

`default_nettype wire

### rtl/lpf_engine.sv
// Back part: stack sequencer; pops one entry per cycle unless the output stalls, then pushes the item.
`default_nettype none

module lpf_engine #(
    parameter int STACK_DEPTH = lpf_pkg::STACK_DEPTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_take,
    input  wire lpf_pkg::lpf_cmd_t  cmd,
    output logic                    lpf_valid,
    input  wire logic               lpf_stall,
    output lpf_pkg::lpf_out_t       lpf_item
);
    import lpf_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);
    localparam logic [CW-1:0] TWO_C   = CW'(2);
    localparam logic [CW-1:0] THREE_C = CW'(3);

    // The top entry lives in flops; the memory holds the entries below it.
    pos_t           mem_pos [STACK_DEPTH];
    len_t           mem_len [STACK_DEPTH];

    logic           busy_reg, busy_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           sec_mem_reg, sec_mem_next;
    logic           overflow_reg, overflow_next;
    logic           res_valid_reg, res_valid_next;
    lpf_cmd_t       cmd_reg;
    pos_t           top_pos_reg;
    len_t           top_len_reg;
    pos_t           sec_pos_reg;
    len_t           sec_len_reg;
    pos_t           rd_pos_reg;
    len_t           rd_len_reg;
    lpf_out_t       res_reg;

    pos_t           sec_pos;
    len_t           sec_len;
    logic           out_free;
    logic           want_pop;
    logic           do_pop;
    logic           finish;
    logic           do_push;
    logic           is_below;
    len_t           pop_len;
    len_t           cur_after;
    logic           more_pops;

    // The entry under the top comes from the memory read of the last pop until the next push, else from flops.
    assign sec_pos = sec_mem_reg ? rd_pos_reg : sec_pos_reg;
    assign sec_len = sec_mem_reg ? rd_len_reg : sec_len_reg;

    // Pop decision and the values of the popped result.
    always_comb
    begin
        out_free  = !res_valid_reg || !lpf_stall;
        want_pop  = busy_reg && (count_reg != '0)
                    && pop_cond(cmd_reg.flush, cmd_reg.pos, cmd_reg.cur, top_pos_reg, top_len_reg);
        do_pop    = want_pop && out_free;
        finish    = busy_reg && !want_pop;
        do_push   = finish && !cmd_reg.flush && (count_reg != DEPTH_C);
        cmd_take  = cmd_valid && (!busy_reg || finish);
        is_below  = below_top(cmd_reg.flush, cmd_reg.pos, top_pos_reg);
        pop_len   = (is_below && (cmd_reg.cur > top_len_reg)) ? cmd_reg.cur : top_len_reg;
        cur_after = (is_below && (top_len_reg < cmd_reg.cur)) ? top_len_reg : cmd_reg.cur;
        // Look one entry ahead so the final result of the item can be marked.
        more_pops = (count_reg >= TWO_C)
                    && pop_cond(cmd_reg.flush, cmd_reg.pos, cur_after, sec_pos, sec_len);
    end

    // Next state of the control registers.
    always_comb
    begin
        busy_next     = busy_reg;
        count_next    = count_reg;
        sec_mem_next  = sec_mem_reg;
        overflow_next = overflow_reg;
        if (finish)
        begin
            busy_next = 1'b0;
        end
        if (cmd_take)
        begin
            busy_next = 1'b1;
        end
        if (do_pop)
        begin
            count_next   = count_reg - ONE_C;
            sec_mem_next = 1'b1;
        end
        else if (do_push)
        begin
            count_next   = count_reg + ONE_C;
            sec_mem_next = 1'b0;
        end
        if (finish && !cmd_reg.flush && (count_reg == DEPTH_C))
        begin
            overflow_next = 1'b1;
        end
        if (do_pop)
        begin
            res_valid_next = 1'b1;
        end
        else
        begin
            res_valid_next = res_valid_reg && lpf_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            count_reg     <= '0;
            sec_mem_reg   <= 1'b0;
            overflow_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            count_reg     <= count_next;
            sec_mem_reg   <= sec_mem_next;
            overflow_reg  <= overflow_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Working item, top and second entries, and the output register.
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            cmd_reg <= cmd;
        end
        else if (do_pop)
        begin
            cmd_reg.cur <= cur_after;
        end
        if (do_pop)
        begin
            top_pos_reg          <= sec_pos;
            top_len_reg          <= sec_len;
            res_reg.factor_pos   <= top_pos_reg;
            res_reg.factor_len   <= pop_len;
            res_reg.last_of_run  <= !more_pops;
            res_reg.overflow     <= overflow_reg;
        end
        else if (do_push)
        begin
            top_pos_reg <= cmd_reg.pos;
            top_len_reg <= cmd_reg.cur;
            sec_pos_reg <= top_pos_reg;
            sec_len_reg <= top_len_reg;
        end
    end

    // Stack memory: the old top moves down on a push, the new second entry is read on a pop.
    always_ff @(posedge clk)
    begin
        if (do_push && (count_reg != '0))
        begin
            mem_pos[AW'(count_reg - ONE_C)] <= top_pos_reg;
            mem_len[AW'(count_reg - ONE_C)] <= top_len_reg;
        end
        if (do_pop && (count_reg >= THREE_C))
        begin
            rd_pos_reg <= mem_pos[AW'(count_reg - THREE_C)];
            rd_len_reg <= mem_len[AW'(count_reg - THREE_C)];
        end
    end

    assign lpf_valid = res_valid_reg;
    assign lpf_item  = res_reg;

endmodule

`default_nettype wire

### tb/tb.sv
// Testbench of the longest previous factor unit, checked against a stack model in a scoreboard.

// Models the unit's stack and holds the factors that are still due from the unit.
class factor_scoreboard;
    lpf_pkg::pos_t     rank_pos[lpf_pkg::STACK_DEPTH_DEF];
    lpf_pkg::len_t     rank_len[lpf_pkg::STACK_DEPTH_DEF];
    int unsigned       stack_fill;
    bit                overflow_flag;
    lpf_pkg::lpf_out_t factors_due[$];
    int unsigned       errors;

    function new();
        stack_fill    = 0;
        overflow_flag = 1'b0;
        errors        = 0;
    endfunction

    function int unsigned pending();
        return factors_due.size();
    endfunction

    // Pops the entries that one accepted rank pops, queues their factors, then pushes the rank.
    function void accept_rank(lpf_pkg::lpf_in_t rank);
        lpf_pkg::pos_t     top_pos;
        lpf_pkg::len_t     top_len;
        lpf_pkg::len_t     cur;
        lpf_pkg::len_t     popped_len;
        lpf_pkg::lpf_out_t held;
        bit                have_held;
        bit                popping;
        cur       = rank.flush ? '0 : rank.lcp_len;
        have_held = 1'b0;
        popping   = 1'b1;
        held      = '0;
        while (popping && stack_fill > 0) begin
            top_pos    = rank_pos[stack_fill-1];
            top_len    = rank_len[stack_fill-1];
            popped_len = '0;
            if (rank.flush || rank.suffix_pos < top_pos) begin
                popped_len = (top_len > cur) ? top_len : cur;
                if (top_len < cur)
                    cur = top_len;
            end
            else if (rank.suffix_pos > top_pos && cur <= top_len)
                popped_len = top_len;
            else
                popping = 1'b0;
            if (popping) begin
                // The previous factor is not the last one of this rank, so it can go out now.
                if (have_held)
                    factors_due.push_back(held);
                held.factor_pos  = top_pos;
                held.factor_len  = popped_len;
                held.last_of_run = 1'b0;
                held.overflow    = overflow_flag;
                have_held        = 1'b1;
                stack_fill--;
            end
        end
        if (have_held) begin
            held.last_of_run = 1'b1;
            factors_due.push_back(held);
        end
        // A flush pushes nothing; a push into a full stack is dropped and flagged.
        if (!rank.flush) begin
            if (stack_fill < lpf_pkg::STACK_DEPTH_DEF) begin
                rank_pos[stack_fill] = rank.suffix_pos;
                rank_len[stack_fill] = cur;
                stack_fill++;
            end
            else
                overflow_flag = 1'b1;
        end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endfunction

    // Compares one factor from the unit with the oldest one due.
    function void check_factor(lpf_pkg::lpf_out_t got);
        lpf_pkg::lpf_out_t want;
        if (factors_due.size() == 0) begin
            $error("factor with none due: factor_pos %0d, factor_len %0d",
                   got.factor_pos, got.factor_len);
            errors++;
        end
        else begin
            want = factors_due.pop_front();
            compare_field("factor_pos", 32'(want.factor_pos), 32'(got.factor_pos));
            compare_field("factor_len", 32'(want.factor_len), 32'(got.factor_len));
            compare_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
            compare_field("overflow", 32'(want.overflow), 32'(got.overflow));
        end
    endfunction
endclass

module tb;
    import lpf_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_CYCLES = 20;

    logic     clk;
    logic     rst_n     = 1'b0;
    logic     sa_valid  = 1'b0;
    logic     sa_stall;
    lpf_in_t  sa_item   = '0;
    logic     lpf_valid;
    logic     lpf_stall = 1'b0;
    lpf_out_t lpf_item;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_left     = 0;
    int unsigned items_sent    = 0;

    // Scratch text with its suffix array and LCP array.
    int txt[0:31];
    int sa_order[0:31];
    int lcp_rank[0:31];

    factor_scoreboard sb;

    longest_previous_factor_unit #(
        .STACK_DEPTH (STACK_DEPTH_DEF)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .sa_valid  (sa_valid),
        .sa_stall  (sa_stall),
        .sa_item   (sa_item),
        .lpf_valid (lpf_valid),
        .lpf_stall (lpf_stall),
        .lpf_item  (lpf_item)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver: checks each result transfer and stalls at random or for a long hold-off.
    always @(posedge clk) begin
        if (rst_n && lpf_valid && !lpf_stall)
            sb.check_factor(lpf_item);
        if (hold_left > 0) begin
            lpf_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
            lpf_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    function automatic lpf_in_t rank_item(int unsigned p, int unsigned l, bit fl);
        lpf_in_t it;
        it.suffix_pos = pos_t'(p);
        it.lcp_len    = len_t'(l);
        it.flush      = fl;
        return it;
    endfunction

    function automatic bit suffix_less(int a, int b, int n);
        int k;
        k = 0;
        while (a + k < n && b + k < n) begin
            if (txt[a+k] != txt[b+k])
                return txt[a+k] < txt[b+k];
            k++;
        end
        return (a + k == n);
    endfunction

    // Offers one item after a random gap and waits for its transfer.
    task automatic send_item(lpf_in_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            sa_valid <= 1'b0;
            @(posedge clk);
        end
        sa_valid <= 1'b1;
        sa_item  <= it;
        @(posedge clk);
        while (sa_stall)
            @(posedge clk);
        sb.accept_rank(it);
        items_sent++;
    endtask

    task automatic send_flush();
        send_item(rank_item($urandom_range(0, 65535), $urandom_range(0, 65535), 1'b1));
    endtask

    task automatic send_noise();
        int unsigned l;
        l = $urandom_range(1) ? $urandom_range(0, 65535) : $urandom_range(0, 7);
        send_item(rank_item($urandom_range(0, 65535), l, $urandom_range(7) == 0));
    endtask

    // Builds a random text, sorts its suffixes and streams the ranks at a random base, then optionally a flush.
    task automatic send_text(int n, int alpha, bit with_flush);
        int i;
        int j;
        int k;
        int tmp;
        int unsigned base;
        for (i = 0; i < n; i++) begin
            txt[i]      = $urandom_range(0, alpha - 1);
            sa_order[i] = i;
        end
        for (i = 1; i < n; i++) begin
            tmp = sa_order[i];
            j   = i - 1;
            while (j >= 0 && suffix_less(tmp, sa_order[j], n)) begin
                sa_order[j+1] = sa_order[j];
                j--;
            end
            sa_order[j+1] = tmp;
        end
        lcp_rank[0] = 0;
        for (i = 1; i < n; i++) begin
            k = 0;
            while (sa_order[i-1] + k < n && sa_order[i] + k < n &&
                   txt[sa_order[i-1]+k] == txt[sa_order[i]+k])
                k++;
            lcp_rank[i] = k;
        end
        base = $urandom_range(0, 65535 - n);
        for (i = 0; i < n; i++)
            send_item(rank_item(base + sa_order[i], lcp_rank[i], 1'b0));
        if (with_flush)
            send_flush();
    endtask

    // Drops valid and waits until every due factor has come back.
    task automatic wait_drained();
        sa_valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Mostly well-formed suffix arrays with random content, some noise and broken ones.
    task automatic run_phase(int unsigned count, int unsigned send_pct, int unsigned recv_pct);
        int unsigned start;
        int unsigned burst;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start         = items_sent;
        while (items_sent - start < count) begin
            if ($urandom_range(99) < 75)
                send_text($urandom_range(2, 14), $urandom_range(1, 4), $urandom_range(9) != 0);
            else begin
                burst = $urandom_range(1, 4);
                repeat (burst) send_noise();
            end
        end
    endtask

    initial begin
        int i;
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty stack, field extremes, equal positions and both pop rules.
        send_item(rank_item(0, 0, 1'b0));
        send_item(rank_item(65535, 65535, 1'b0));
        send_item(rank_item(65535, 0, 1'b0));
        send_item(rank_item(100, 7, 1'b0));
        send_item(rank_item(200, 0, 1'b0));
        send_item(rank_item(300, 5, 1'b0));
        send_item(rank_item(65535, 65535, 1'b1));
        send_item(rank_item(0, 0, 1'b1));
        send_item(rank_item(0, 65535, 1'b0));
        send_item(rank_item(65535, 0, 1'b0));
        send_flush();
        // A short text with a known suffix array and LCP array.
        send_item(rank_item(5, 0, 1'b0));
        send_item(rank_item(3, 1, 1'b0));
        send_item(rank_item(1, 3, 1'b0));
        send_item(rank_item(0, 0, 1'b0));
        send_item(rank_item(4, 0, 1'b0));
        send_item(rank_item(2, 2, 1'b0));
        send_flush();
        wait_drained();

        run_phase(20, 17, 79);
        wait_drained();
        run_phase(20, 79, 17);
        wait_drained();
        run_phase(20, 0, 0);
        wait_drained();

        // Long receiver hold-off while descending positions pop one entry each.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left     = HOLD_CYCLES;
        for (i = 0; i < 24; i++)
            send_item(rank_item(2000 - 10 * i, $urandom_range(0, 15), 1'b0));
        send_flush();
        wait_drained();

        // Fill the stack with rising lengths, overrun it, then pop it empty.
        recv_idle_pct = 30;
        for (i = 0; i < STACK_DEPTH_DEF; i++)
            send_item(rank_item(10 + 3 * i, i, 1'b0));
        send_item(rank_item(500, 200, 1'b0));
        send_item(rank_item(600, 300, 1'b0));
        send_item(rank_item(2, 1, 1'b0));
        send_flush();
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #400000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
